>>> rtl/flrp_pkg.sv
// Shared types, character codes and character-class helpers for the
// feature-location range parser. No dependencies.
`default_nettype none

package flrp_pkg;

   localparam int unsigned COORD_BITS_DEF = 31;

   // lexer mode
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_INT  = 2'd1,
      MODE_WORD = 2'd2
   } mode_type;

   // location flag bit positions
   localparam int unsigned FLAG_POINT   = 0;
   localparam int unsigned FLAG_UMIN    = 1;
   localparam int unsigned FLAG_UMAX    = 2;
   localparam int unsigned FLAG_FUZZY   = 3;
   localparam int unsigned FLAG_BETWEEN = 4;
   localparam logic [4:0]  FLAGS_RESET  = 5'b00001;

   // character codes
   localparam logic [6:0] CH_DOT    = 7'h2E;
   localparam logic [6:0] CH_CARET  = 7'h5E;
   localparam logic [6:0] CH_LT     = 7'h3C;
   localparam logic [6:0] CH_GT     = 7'h3E;
   localparam logic [6:0] CH_COMMA  = 7'h2C;
   localparam logic [6:0] CH_RPAREN = 7'h29;

   // one input request as held in the input register
   typedef struct packed {
      logic [6:0] char_code;
      logic       is_last;
   } req_item_type;

   function automatic logic is_digit(input logic [6:0] ch);
      return ch inside {[7'h30:7'h39]};
   endfunction

   function automatic logic is_alpha(input logic [6:0] ch);
      return ch inside {[7'h41:7'h5A], [7'h61:7'h7A]};
   endfunction

   function automatic logic is_space(input logic [6:0] ch);
      return ch inside {7'h20, 7'h09, 7'h0A, 7'h0D, 7'h08, 7'h0B, 7'h0C};
   endfunction

endpackage

`default_nettype wire

>>> rtl/flrp_in_stage.sv
// Input register of the parser: holds one request until the core takes it.
// Depends on flrp_pkg.
`default_nettype none

module flrp_in_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  [6:0]             req_char_code,
   input  wire                    req_is_last,
   output logic                   item_valid,
   output flrp_pkg::req_item_type item,
   input  wire                    item_take
);

   logic                   vld_ff, vld_in;
   flrp_pkg::req_item_type item_ff;
   logic                   accept;

   assign req_ready  = !vld_ff || item_take;
   assign accept     = req_valid && req_ready;
   assign item_valid = vld_ff;
   assign item       = item_ff;

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (item_take) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{char_code: req_char_code, is_last: req_is_last};
      end
   end

endmodule

`default_nettype wire

>>> rtl/flrp_core.sv
// Lexer, coordinate store and range selection; one request per unstalled cycle.
// Depends on flrp_pkg.
`default_nettype none

module flrp_core #(
   parameter int unsigned COORD_BITS = flrp_pkg::COORD_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    item_valid,
   input  flrp_pkg::req_item_type item,
   output logic                   item_take,
   input  wire                    out_room,
   output logic                   res_load,
   output logic [COORD_BITS-1:0]  res_start,
   output logic [COORD_BITS-1:0]  res_end,
   output logic                   res_flush
);

   typedef struct packed {
      logic [COORD_BITS-1:0] sv0;
      logic [COORD_BITS-1:0] sv1;
      logic [COORD_BITS-1:0] ev0;
      logic [COORD_BITS-1:0] ev1;
      logic [1:0]            sc;
      logic [1:0]            ec;
      logic [COORD_BITS-1:0] acc;
      logic                  ovf;
      flrp_pkg::mode_type    mode;
      logic                  pdot;
      logic [4:0]            flags;
   } pst_type;

   typedef struct packed {
      pst_type               st;
      logic                  vld;
      logic [COORD_BITS-1:0] lo;
      logic [COORD_BITS-1:0] hi;
   } emit_type;

   function automatic pst_type reset_state();
      pst_type r;
      r       = '0;
      r.mode  = flrp_pkg::MODE_IDLE;
      r.flags = flrp_pkg::FLAGS_RESET;
      return r;
   endfunction

   function automatic pst_type add_coord(input pst_type s, input logic [COORD_BITS-1:0] v);
      pst_type r;
      r = s;
      if (s.flags[flrp_pkg::FLAG_POINT]) begin
         if (s.sc == 2'd0) begin
            r.sv0 = v;
         end else if (s.sc == 2'd1) begin
            r.sv1 = v;
         end
         if (s.sc != 2'd3) begin
            r.sc = s.sc + 2'd1;
         end
      end else begin
         if (s.ec == 2'd0) begin
            r.ev0 = v;
         end else if (s.ec == 2'd1) begin
            r.ev1 = v;
         end
         if (s.ec != 2'd3) begin
            r.ec = s.ec + 2'd1;
         end
      end
      return r;
   endfunction

   function automatic pst_type end_token(input pst_type s);
      pst_type r;
      r = s;
      if (s.mode == flrp_pkg::MODE_INT) begin
         r = add_coord(s, s.ovf ? '0 : s.acc);
      end
      r.mode = flrp_pkg::MODE_IDLE;
      r.acc  = '0;
      r.ovf  = 1'b0;
      return r;
   endfunction

   function automatic emit_type emit_range(input pst_type s);
      emit_type r;
      r.st  = s;
      r.vld = 1'b0;
      r.lo  = '0;
      r.hi  = '0;
      if (s.sc != 2'd0 || s.ec != 2'd0) begin
         if (s.flags[flrp_pkg::FLAG_BETWEEN]) begin
            r.vld = 1'b1; r.lo = s.sv0; r.hi = s.sv1;
         end else if (s.sc == 2'd1 && s.ec == 2'd0) begin
            if (s.flags[flrp_pkg::FLAG_UMIN] || s.flags[flrp_pkg::FLAG_UMAX] ||
                s.flags[flrp_pkg::FLAG_POINT]) begin
               r.vld = 1'b1; r.lo = s.sv0; r.hi = s.sv0;
            end
         end else if (s.sc == 2'd2 && s.ec == 2'd0) begin
            r.vld = 1'b1; r.lo = s.sv0; r.hi = s.sv1;
         end else if (s.sc == 2'd1 && s.ec == 2'd1) begin
            r.vld = 1'b1; r.lo = s.sv0; r.hi = s.ev0;
         end else if (s.sc == 2'd2 && s.ec == 2'd1) begin
            r.vld = 1'b1; r.lo = s.sv1; r.hi = s.ev0;
         end else if ((s.sc == 2'd1 || s.sc == 2'd2) && s.ec == 2'd2) begin
            r.vld = 1'b1; r.lo = s.sv0; r.hi = s.ev1;
         end
         // counts seen, so coordinates and flags go back to their reset values
         r.st.sv0   = '0;
         r.st.sv1   = '0;
         r.st.ev0   = '0;
         r.st.ev1   = '0;
         r.st.sc    = 2'd0;
         r.st.ec    = 2'd0;
         r.st.flags = flrp_pkg::FLAGS_RESET;
      end
      return r;
   endfunction

   pst_type                state_ff, state_in;
   emit_type               em_char, em_flush;
   logic                   handled;
   logic                   adv;
   logic [COORD_BITS+3:0]  acc_x10;
   logic [6:0]             ch;

   assign ch = item.char_code;

   // acc*10 + digit; the top four bits flag a value beyond the coordinate range
   assign acc_x10 = ({4'b0, state_ff.acc} << 3) + ({4'b0, state_ff.acc} << 1)
                  + {{COORD_BITS{1'b0}}, ch[3:0]};

   always_comb begin
      state_in = state_ff;
      em_char  = '0;
      em_flush = '0;
      handled  = 1'b0;
      if (state_ff.mode == flrp_pkg::MODE_INT && flrp_pkg::is_digit(ch)) begin
         if (!state_ff.ovf) begin
            if (acc_x10[COORD_BITS+3:COORD_BITS] != 4'd0) begin
               state_in.ovf = 1'b1;
               state_in.acc = '0;
            end else begin
               state_in.acc = acc_x10[COORD_BITS-1:0];
            end
         end
      end else if (state_ff.mode == flrp_pkg::MODE_WORD &&
                   (flrp_pkg::is_alpha(ch) || flrp_pkg::is_digit(ch) ||
                    ch == flrp_pkg::CH_DOT)) begin
         // word continues, dropped
      end else begin
         state_in = end_token(state_ff);
         if (state_in.pdot) begin
            state_in.pdot = 1'b0;
            if (ch == flrp_pkg::CH_DOT) begin
               state_in.flags[flrp_pkg::FLAG_POINT] = 1'b0;
               handled = 1'b1;
            end else begin
               state_in.flags[flrp_pkg::FLAG_FUZZY] = 1'b1;
            end
         end
         if (!handled) begin
            if (flrp_pkg::is_space(ch)) begin
               // skipped
            end else if (flrp_pkg::is_digit(ch)) begin
               state_in.mode = flrp_pkg::MODE_INT;
               state_in.acc  = {{(COORD_BITS-4){1'b0}}, ch[3:0]};
               state_in.ovf  = 1'b0;
            end else if (flrp_pkg::is_alpha(ch)) begin
               state_in.mode = flrp_pkg::MODE_WORD;
            end else begin
               case (ch)
                  flrp_pkg::CH_DOT:    state_in.pdot = 1'b1;
                  flrp_pkg::CH_CARET:  state_in.flags[flrp_pkg::FLAG_BETWEEN] = 1'b1;
                  flrp_pkg::CH_LT:     state_in.flags[flrp_pkg::FLAG_UMIN] = 1'b1;
                  flrp_pkg::CH_GT:     state_in.flags[flrp_pkg::FLAG_UMAX] = 1'b1;
                  flrp_pkg::CH_COMMA: begin
                     em_char  = emit_range(state_in);
                     state_in = em_char.st;
                  end
                  flrp_pkg::CH_RPAREN: begin
                     if (state_in.flags[flrp_pkg::FLAG_FUZZY]) begin
                        state_in.flags[flrp_pkg::FLAG_FUZZY] = 1'b0;
                     end else begin
                        em_char  = emit_range(state_in);
                        state_in = em_char.st;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
      if (item.is_last) begin
         // end-of-string flush: close any token, a trailing lone dot is fuzzy
         state_in = end_token(state_in);
         if (state_in.pdot) begin
            state_in.pdot = 1'b0;
            state_in.flags[flrp_pkg::FLAG_FUZZY] = 1'b1;
         end
         em_flush = emit_range(state_in);
         state_in = reset_state();
      end
   end

   assign res_flush = !em_char.vld;
   assign res_start = em_char.vld ? em_char.lo : em_flush.lo;
   assign res_end   = em_char.vld ? em_char.hi : em_flush.hi;

   // stall only when a range is due and the result register is full
   assign adv       = item_valid && (out_room || !(em_char.vld || em_flush.vld));
   assign item_take = adv;
   assign res_load  = adv && (em_char.vld || em_flush.vld);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
      end else if (adv) begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && item.is_last) |=> (state_ff.sc == 2'd0 && state_ff.ec == 2'd0 &&
         state_ff.mode == flrp_pkg::MODE_IDLE && !state_ff.pdot &&
         state_ff.flags == flrp_pkg::FLAGS_RESET))
      else $error("parse state not cleared after last character");

   a_end_after_dots: assert property (@(posedge clock) disable iff (reset)
      (state_ff.ec != 2'd0) |-> !state_ff.flags[flrp_pkg::FLAG_POINT])
      else $error("end coordinate held while point flag set");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff.ovf |-> (state_ff.acc == '0 && state_ff.mode == flrp_pkg::MODE_INT))
      else $error("overflowed integer not held at zero");
`endif

endmodule

`default_nettype wire

>>> rtl/flrp_out_stage.sv
// Result register of the parser: holds one range until the receiver takes it.
// Depends on flrp_pkg.
`default_nettype none

module flrp_out_stage #(
   parameter int unsigned COORD_BITS = flrp_pkg::COORD_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   res_load,
   input  wire  [COORD_BITS-1:0] res_start,
   input  wire  [COORD_BITS-1:0] res_end,
   input  wire                   res_flush,
   output logic                  out_room,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [COORD_BITS-1:0] rsp_range_start,
   output logic [COORD_BITS-1:0] rsp_range_end,
   output logic                  rsp_from_flush
);

   logic                  vld_ff, vld_in;
   logic [COORD_BITS-1:0] start_ff, end_ff;
   logic                  flush_ff;

   assign out_room        = !vld_ff || rsp_ready;
   assign rsp_valid       = vld_ff;
   assign rsp_range_start = start_ff;
   assign rsp_range_end   = end_ff;
   assign rsp_from_flush  = flush_ff;

   always_comb begin
      if (res_load) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         start_ff <= res_start;
         end_ff   <= res_end;
         flush_ff <= res_flush;
      end
   end

endmodule

`default_nettype wire

>>> rtl/feature_location_range_parser.sv
// Feature-location range parser, top level.
// Depends on flrp_pkg, flrp_in_stage, flrp_core and flrp_out_stage.
//
// Use:
//  - req_ channel: one ASCII character per request (req_char_code), with
//    req_is_last marking the final character of a location string.
//  - rsp_ channel: at most one range per request: rsp_range_start,
//    rsp_range_end and rsp_from_flush (set when the range came from the
//    end-of-string flush rather than a ',' or ')').
//  - Path: a request is held in the input register; its range is loaded
//    into the result register when that register has room, and is on
//    rsp_valid from then on.
//  - Throughput: one request per cycle while not stalled. The lexer and
//    coordinate store update in a single pass between the input and
//    result registers; the integer accumulate is a shift-and-add times ten.
//  - Stalls: while rsp_ready is low a full result register holds its range;
//    requests that produce no range still pass, one that produces a range
//    waits in the input register and req_ready drops.
//  - Reset (synchronous, active high) empties both registers and returns
//    the parse state to idle with only the point flag set.
`default_nettype none

module feature_location_range_parser #(
   parameter int unsigned COORD_BITS = flrp_pkg::COORD_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [6:0]            req_char_code,
   input  wire                   req_is_last,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [COORD_BITS-1:0] rsp_range_start,
   output logic [COORD_BITS-1:0] rsp_range_end,
   output logic                  rsp_from_flush
);

   flrp_pkg::req_item_type item;
   logic                   item_valid;
   logic                   item_take;
   logic                   out_room;
   logic                   res_load;
   logic [COORD_BITS-1:0]  res_start;
   logic [COORD_BITS-1:0]  res_end;
   logic                   res_flush;

   // input register: one character request
   flrp_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take)
   );

   // lexer, coordinate store and range selection
   flrp_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_room   (out_room),
      .res_load   (res_load),
      .res_start  (res_start),
      .res_end    (res_end),
      .res_flush  (res_flush)
   );

   // result register towards the receiver
   flrp_out_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_out (
      .clock           (clock),
      .reset           (reset),
      .res_load        (res_load),
      .res_start       (res_start),
      .res_end         (res_end),
      .res_flush       (res_flush),
      .out_room        (out_room),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_start (rsp_range_start),
      .rsp_range_end   (rsp_range_end),
      .rsp_from_flush  (rsp_from_flush)
   );

endmodule

`default_nettype wire

>>> tb/sv/flrp_range_checker.sv
// Scoreboard for the feature-location range parser: watches both channels,
// predicts each range from the accepted requests and compares field by field.
// Depends on flrp_pkg (lexer modes, flag positions, character codes).
module flrp_range_checker
   import flrp_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_ready,
   input  wire [6:0]                req_char_code,
   input  wire                      req_is_last,
   input  wire                      rsp_valid,
   input  wire                      rsp_ready,
   input  wire [COORD_BITS_DEF-1:0] rsp_range_start,
   input  wire [COORD_BITS_DEF-1:0] rsp_range_end,
   input  wire                      rsp_from_flush,
   output int                       fail_count,
   output int                       pending_count
);

   localparam int CW = COORD_BITS_DEF;
   localparam longint unsigned COORD_MAX = (64'd1 << CW) - 1;

   localparam logic [6:0] CH_BS    = 7'h08;
   localparam logic [6:0] CH_CR    = 7'h0D;
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_NINE  = 7'h39;
   localparam logic [6:0] CH_UA    = 7'h41;
   localparam logic [6:0] CH_UZ    = 7'h5A;
   localparam logic [6:0] CH_LA    = 7'h61;
   localparam logic [6:0] CH_LZ    = 7'h7A;

   typedef struct packed {
      logic [CW-1:0] lo;
      logic [CW-1:0] hi;
      logic          from_flush;
   } range_type;

   // parse state mirror
   logic [CW-1:0] start_coord [2];
   logic [CW-1:0] stop_coord [2];
   logic [1:0]    start_seen;
   logic [1:0]    stop_seen;
   logic [CW-1:0] accum;
   logic          accum_ovf;
   mode_type      lex_mode;
   logic          dot_waiting;
   logic [4:0]    loc_flags;

   range_type     range_q [$];

   function automatic void clear_coords();
      start_coord[0] = '0;
      start_coord[1] = '0;
      stop_coord[0]  = '0;
      stop_coord[1]  = '0;
      start_seen     = '0;
      stop_seen      = '0;
   endfunction

   function automatic void reset_parse();
      clear_coords();
      accum       = '0;
      accum_ovf   = 1'b0;
      lex_mode    = MODE_IDLE;
      dot_waiting = 1'b0;
      loc_flags   = FLAGS_RESET;
   endfunction

   // a finished integer goes to the start side until ".." clears the point flag
   function automatic void close_token();
      logic [CW-1:0] v;
      if (lex_mode == MODE_INT) begin
         v = accum_ovf ? '0 : accum;
         if (loc_flags[FLAG_POINT]) begin
            if (start_seen < 2'd2) start_coord[start_seen[0]] = v;
            if (start_seen < 2'd3) start_seen = start_seen + 2'd1;
         end else begin
            if (stop_seen < 2'd2) stop_coord[stop_seen[0]] = v;
            if (stop_seen < 2'd3) stop_seen = stop_seen + 2'd1;
         end
      end
      lex_mode  = MODE_IDLE;
      accum     = '0;
      accum_ovf = 1'b0;
   endfunction

   function automatic bit close_location(input logic flush, output range_type r);
      bit hit;
      hit = 1'b0;
      r   = '0;
      if (start_seen == 2'd0 && stop_seen == 2'd0) return 1'b0;
      if (loc_flags[FLAG_BETWEEN]) begin
         r.lo = start_coord[0]; r.hi = start_coord[1]; hit = 1'b1;
      end else if (start_seen == 2'd1 && stop_seen == 2'd0) begin
         if (loc_flags[FLAG_UMIN] || loc_flags[FLAG_UMAX] || loc_flags[FLAG_POINT]) begin
            r.lo = start_coord[0]; r.hi = start_coord[0]; hit = 1'b1;
         end
      end else if (start_seen == 2'd2 && stop_seen == 2'd0) begin
         r.lo = start_coord[0]; r.hi = start_coord[1]; hit = 1'b1;
      end else if (start_seen == 2'd1 && stop_seen == 2'd1) begin
         r.lo = start_coord[0]; r.hi = stop_coord[0]; hit = 1'b1;
      end else if (start_seen == 2'd2 && stop_seen == 2'd1) begin
         r.lo = start_coord[1]; r.hi = stop_coord[0]; hit = 1'b1;
      end else if ((start_seen == 2'd1 || start_seen == 2'd2) && stop_seen == 2'd2) begin
         r.lo = start_coord[0]; r.hi = stop_coord[1]; hit = 1'b1;
      end
      r.from_flush = flush;
      clear_coords();
      loc_flags = FLAGS_RESET;
      return hit;
   endfunction

   // one character through the lexer; returns 1 when a range comes out
   function automatic bit parse_char(input logic [6:0] c, input logic last,
                                     output range_type r);
      bit got, used, digit, alpha, space;
      longint unsigned d, wide;
      got   = 1'b0;
      used  = 1'b0;
      r     = '0;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      alpha = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
      space = (c >= CH_BS && c <= CH_CR) || c == CH_SPACE;
      if (lex_mode == MODE_INT && digit) begin
         d    = c - CH_ZERO;
         wide = accum;
         if (!accum_ovf) begin
            if (wide > (COORD_MAX - d) / 10) begin
               accum_ovf = 1'b1;
               accum     = '0;
            end else begin
               wide  = wide * 10 + d;
               accum = wide[CW-1:0];
            end
         end
      end else if (!(lex_mode == MODE_WORD && (alpha || digit || c == CH_DOT))) begin
         close_token();
         if (dot_waiting) begin
            dot_waiting = 1'b0;
            if (c == CH_DOT) begin
               loc_flags[FLAG_POINT] = 1'b0;
               used = 1'b1;
            end else begin
               loc_flags[FLAG_FUZZY] = 1'b1;
            end
         end
         if (!used && !space) begin
            if (digit) begin
               lex_mode  = MODE_INT;
               accum     = c - CH_ZERO;
               accum_ovf = 1'b0;
            end else if (alpha) begin
               lex_mode = MODE_WORD;
            end else if (c == CH_DOT) begin
               dot_waiting = 1'b1;
            end else if (c == CH_CARET) begin
               loc_flags[FLAG_BETWEEN] = 1'b1;
            end else if (c == CH_LT) begin
               loc_flags[FLAG_UMIN] = 1'b1;
            end else if (c == CH_GT) begin
               loc_flags[FLAG_UMAX] = 1'b1;
            end else if (c == CH_COMMA) begin
               got = close_location(1'b0, r);
            end else if (c == CH_RPAREN) begin
               if (loc_flags[FLAG_FUZZY]) loc_flags[FLAG_FUZZY] = 1'b0;
               else got = close_location(1'b0, r);
            end
         end
      end
      if (last) begin
         close_token();
         if (dot_waiting) begin
            dot_waiting = 1'b0;
            loc_flags[FLAG_FUZZY] = 1'b1;
         end
         if (!got) got = close_location(1'b1, r);
         reset_parse();
      end
      return got;
   endfunction

   // responses are taken before the request of the same edge: a range is
   // never offered in the cycle its request is accepted
   always @(posedge clock) begin : watch
      range_type want, made;
      if (reset) begin
         reset_parse();
         range_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (range_q.size() == 0) begin
               $error("unexpected range: start %0d, end %0d, flush %0d",
                      rsp_range_start, rsp_range_end, rsp_from_flush);
               fail_count++;
            end else begin
               want = range_q.pop_front();
               if (rsp_range_start !== want.lo) begin
                  $error("range_start: expected %0d, actual %0d", want.lo, rsp_range_start);
                  fail_count++;
               end
               if (rsp_range_end !== want.hi) begin
                  $error("range_end: expected %0d, actual %0d", want.hi, rsp_range_end);
                  fail_count++;
               end
               if (rsp_from_flush !== want.from_flush) begin
                  $error("from_flush: expected %0d, actual %0d",
                         want.from_flush, rsp_from_flush);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (parse_char(req_char_code, req_is_last, made)) range_q.push_back(made);
         end
      end
      pending_count = range_q.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the feature-location range parser: clock, reset, request
// stimulus, response back-pressure, watchdog and verdict.
// Depends on flrp_pkg, feature_location_range_parser and flrp_range_checker.
module tb_top;

   import flrp_pkg::*;

   localparam int CW = COORD_BITS_DEF;

   localparam int IDLE_PCT       = 35;    // chance of a gap per cycle, each side
   localparam int RANDOM_ITEMS   = 1900;
   localparam int HOLD_CYCLES    = 400;   // long response hold-off
   localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake
   localparam int DRAIN_CYCLES   = 20;

   localparam logic [6:0] CH_NUL    = 7'h00;
   localparam logic [6:0] CH_BS     = 7'h08;
   localparam logic [6:0] CH_CR     = 7'h0D;
   localparam logic [6:0] CH_SPACE  = 7'h20;
   localparam logic [6:0] CH_LPAREN = 7'h28;
   localparam logic [6:0] CH_LA     = 7'h61;
   localparam logic [6:0] CH_LZ     = 7'h7A;
   localparam logic [6:0] CH_DEL    = 7'h7F;

   logic          clock         = 1'b0;
   logic          reset         = 1'b1;
   logic          req_valid     = 1'b0;
   logic [6:0]    req_char_code = '0;
   logic          req_is_last   = 1'b0;
   logic          rsp_ready     = 1'b0;
   wire           req_ready;
   wire           rsp_valid;
   wire [CW-1:0]  rsp_range_start;
   wire [CW-1:0]  rsp_range_end;
   wire           rsp_from_flush;

   int            fail_count;
   int            pending_count;
   int            quiet_cycles = 0;

   // shared between the request and response sides
   bit            calm         = 1'b0;  // no gaps on either side
   bit            hold_request = 1'b0;  // asks the response side for one long hold

   // characters of all location strings, with the end-of-string marks beside
   logic [6:0]    char_q [$];
   bit            last_q [$];

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   feature_location_range_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_start (rsp_range_start),
      .rsp_range_end   (rsp_range_end),
      .rsp_from_flush  (rsp_from_flush)
   );

   flrp_range_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_start (rsp_range_start),
      .rsp_range_end   (rsp_range_end),
      .rsp_from_flush  (rsp_from_flush),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   // ---------------------------------------------------------------------
   // String building
   // ---------------------------------------------------------------------

   task automatic add_char(input logic [6:0] c);
      char_q.push_back(c);
      last_q.push_back(1'b0);
   endtask

   task automatic add_text(input string s);
      byte b;
      for (int j = 0; j < s.len(); j++) begin
         b = s[j];
         add_char(b[6:0]);
      end
   endtask

   // marks the most recent character as the end of its string
   task automatic end_record();
      last_q[last_q.size()-1] = 1'b1;
   endtask

   // one or two whitespace characters of any kind
   task automatic add_gap();
      repeat ($urandom_range(2, 1))
         add_char($urandom_range(1) ? CH_SPACE : 7'($urandom_range(CH_CR, CH_BS)));
   endtask

   // mostly short coordinates, with the 31-bit edge and overflow mixed in
   function automatic string coord_text();
      case ($urandom_range(11))
         0: return "2147483647";
         1: return "2147483648";
         2: return $sformatf("%0d", 32'd2147483000 + $urandom_range(1295));
         3: return $sformatf("%0d%0d", $urandom_range(99999, 10000),
                             $urandom_range(999999, 100000));
         4: return "0";
         5: return $sformatf("%0d", $urandom);
         default: return $sformatf("%0d", $urandom_range(99999));
      endcase
   endfunction

   // [<]a..[>]b with stray whitespace
   task automatic add_span();
      if ($urandom_range(3) == 0) add_char(CH_LT);
      add_text(coord_text());
      if ($urandom_range(5) == 0) add_gap();
      add_text("..");
      if ($urandom_range(3) == 0) add_char(CH_GT);
      add_text(coord_text());
   endtask

   task automatic add_location();
      case ($urandom_range(11))
         0, 1, 2: add_span();
         3: begin
            // single base, possibly unbounded
            case ($urandom_range(2))
               0: add_char(CH_LT);
               1: add_char(CH_GT);
               default: ;
            endcase
            add_text(coord_text());
         end
         4: begin
            // a^b, sometimes with the second side missing
            add_text(coord_text());
            add_char(CH_CARET);
            if ($urandom_range(3) != 0) add_text(coord_text());
         end
         5: begin
            // fuzzy (a.b), optionally as the start of a span
            add_char(CH_LPAREN);
            add_text(coord_text());
            add_char(CH_DOT);
            add_text(coord_text());
            add_char(CH_RPAREN);
            if ($urandom_range(1)) begin
               add_text("..");
               add_text(coord_text());
            end
         end
         6: begin
            // more coordinates on one side than a range uses
            add_text(coord_text());
            if ($urandom_range(1)) begin
               add_char(CH_DOT);
               add_text(coord_text());
            end
            add_text("..");
            add_text(coord_text());
            if ($urandom_range(1)) begin
               add_text("..");
               add_text(coord_text());
            end
         end
         7, 8: begin
            // a word such as an accession or operator name ahead of a span
            repeat ($urandom_range(4, 1)) add_char(7'($urandom_range(CH_LZ, CH_LA)));
            if ($urandom_range(1)) add_text(coord_text());
            if ($urandom_range(2) == 0) add_char(CH_DOT);
            add_char(CH_LPAREN);
            add_span();
         end
         9: begin
            // noise: any code at all
            repeat ($urandom_range(6, 1)) add_char(7'($urandom_range(127)));
         end
         10: add_text(coord_text());
         default: ;
      endcase
   endtask

   task automatic add_record();
      repeat ($urandom_range(4, 1)) begin
         add_location();
         case ($urandom_range(4))
            0, 1: add_char(CH_COMMA);
            2: add_char(CH_RPAREN);
            3: begin
               add_gap();
               add_char(CH_COMMA);
            end
            default: if ($urandom_range(1)) add_gap();
         endcase
      end
      // occasionally a trailing lone dot right before the end of string
      if ($urandom_range(7) == 0) add_char(CH_DOT);
      end_record();
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   initial begin : stimulus
      int directed_len;
      int hold_at;
      int calm_from;
      int calm_to;

      // directed strings: bounds and flags, between, fuzzy close with a
      // trailing dot and too many starts, an empty comma and ends without
      // starts, then a word, whitespace and the lowest and highest codes
      add_text("<3..>4)");
      end_record();
      add_text("1^2,");
      end_record();
      add_text("5.6)7.");
      end_record();
      add_text(",..9");
      end_record();
      add_text("x1 2");
      add_char(CH_NUL);
      add_char(CH_DEL);
      end_record();
      directed_len = char_q.size();

      while (char_q.size() < directed_len + RANDOM_ITEMS) add_record();

      hold_at   = directed_len + 300;
      calm_from = directed_len + 800;
      calm_to   = directed_len + 1100;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < char_q.size(); i++) begin
         calm = (i >= calm_from && i < calm_to);
         if (i == hold_at) hold_request = 1'b1;

         // after the directed part, stop and let every range come out
         if (i == directed_len) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (pending_count != 0);
            @(posedge clock);
         end

         while (!calm && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_char_code <= char_q[i];
         req_is_last   <= last_q[i];
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      // drain: the watchdog catches a range that never arrives
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("[feature_location_range_parser] OK");
      else
         $display("[feature_location_range_parser] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure and one long hold, during which
   // the request side keeps offering so the parser fills and stalls
   // ---------------------------------------------------------------------

   initial begin : sink
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: ends the run if no handshake happens for too long
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[feature_location_range_parser] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

>>> filelist.f
rtl/flrp_pkg.sv
rtl/flrp_in_stage.sv
rtl/flrp_core.sv
rtl/flrp_out_stage.sv
rtl/feature_location_range_parser.sv
tb/sv/flrp_range_checker.sv
tb/sv/tb_top.sv
